### rtl/fpdt_pkg.sv
// ----------------------------------------------------------------------------
// fpdt_pkg
// Shared types and constants for the fixed-point to decimal thousandths
// converter.
// ----------------------------------------------------------------------------
package fpdt_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int RAW_W         = 32;
   localparam int WHOLE_W       = 31;
   localparam int THOU_W        = 10;
   localparam int CNT_W         = 5;
   localparam int SCALED_W      = 41;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [THOU_W-1:0] SCALE = 10'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INT_BITS   = 2'd0,
      CSR_FRAC_BITS  = 2'd1,
      CSR_ROUND_MODE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      RND_TRUNC   = 2'd0,
      RND_NEAREST = 2'd1,
      RND_UP      = 2'd2,
      RND_DOWN    = 2'd3
   } round_mode_type;

   localparam logic [CNT_W-1:0] INT_BITS_RST  = 5'd16;
   localparam logic [CNT_W-1:0] FRAC_BITS_RST = 5'd16;

   typedef struct packed {
      round_mode_type   mode;
      logic [CNT_W-1:0] frac_bits;
      logic             negative;
   } round_ctl_type;

endpackage

### rtl/fpdt_round.sv
// ----------------------------------------------------------------------------
// fpdt_round
// Rounds a fraction scaled by 1000 back to thousandths and flags a carry
// into the whole part.
// ----------------------------------------------------------------------------
module fpdt_round (
   input  logic [fpdt_pkg::SCALED_W-1:0] scaled,
   input  fpdt_pkg::round_ctl_type        ctl,
   output logic [fpdt_pkg::THOU_W-1:0]   thousandths,
   output logic                          carry
);

   logic [fpdt_pkg::SCALED_W-1:0] shifted;
   logic [fpdt_pkg::SCALED_W-1:0] rem;
   logic [fpdt_pkg::SCALED_W-1:0] half;
   logic [fpdt_pkg::THOU_W-1:0]   quot;
   logic                          rem_nz;
   logic                          up;
   logic [fpdt_pkg::THOU_W:0]     sum;

   always_comb begin
      shifted = scaled >> ctl.frac_bits;
      quot    = shifted[fpdt_pkg::THOU_W-1:0];
      rem     = scaled & ((fpdt_pkg::SCALED_W'(1) << ctl.frac_bits) - fpdt_pkg::SCALED_W'(1));
      half    = fpdt_pkg::SCALED_W'(1) << (ctl.frac_bits - fpdt_pkg::CNT_W'(1));
      rem_nz  = (rem != '0);
      case (ctl.mode)
         fpdt_pkg::RND_NEAREST: begin
            up = (rem > half) || ((rem == half) && quot[0]);
         end
         fpdt_pkg::RND_UP: begin
            up = !ctl.negative && rem_nz;
         end
         fpdt_pkg::RND_DOWN: begin
            up = ctl.negative && rem_nz;
         end
         default: begin
            up = 1'b0;
         end
      endcase
      if (ctl.frac_bits == '0) begin
         up = 1'b0;
      end
      sum   = {1'b0, quot} + {{fpdt_pkg::THOU_W{1'b0}}, up};
      carry = (sum == {1'b0, fpdt_pkg::SCALE});
      if (carry || (ctl.frac_bits == '0)) begin
         thousandths = '0;
      end else begin
         thousandths = sum[fpdt_pkg::THOU_W-1:0];
      end
   end

endmodule

### rtl/fixed_point_to_decimal_thousandths.sv
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_thousandths
// Converts a two's-complement fixed-point word into sign, whole part and
// rounded thousandths.
// ----------------------------------------------------------------------------
// Three register stages: the input word, then magnitude/whole part with the
// fraction multiplied by 1000, then the rounded result. One word is taken per
// clock unless rsp_ready stalls the pipe; rsp_valid rises once the word has
// passed the input, magnitude and result registers. Bubbles collapse, so a
// stall blocks the input only once all three stages hold a word. The config
// registers, read live by stages two and three, are set via always-ready csr_*.
module fixed_point_to_decimal_thousandths #(
   parameter int WORD_BITS = fpdt_pkg::WORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fpdt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fpdt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fpdt_pkg::RAW_W-1:0]        req_raw_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_negative,
   output logic [fpdt_pkg::WHOLE_W-1:0]      rsp_whole_part,
   output logic [fpdt_pkg::THOU_W-1:0]       rsp_thousandths
);

   localparam int PW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

   logic [fpdt_pkg::CNT_W-1:0]    int_bits_ff, int_bits_in;
   logic [fpdt_pkg::CNT_W-1:0]    frac_bits_ff, frac_bits_in;
   fpdt_pkg::round_mode_type      mode_ff, mode_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic [WORD_BITS-1:0]          raw_ff, raw_in;
   logic                          s2_valid_ff, s2_valid_in;
   logic                          neg_ff, neg_in;
   logic [fpdt_pkg::RAW_W-1:0]    whole_ff, whole_in;
   logic [fpdt_pkg::SCALED_W-1:0] scaled_ff, scaled_in;
   logic                          out_valid_ff, out_valid_in;
   logic                          out_neg_ff, out_neg_in;
   logic [fpdt_pkg::WHOLE_W-1:0]  out_whole_ff, out_whole_in;
   logic [fpdt_pkg::THOU_W-1:0]   out_thou_ff, out_thou_in;

   logic                          s1_adv, s2_adv, s3_adv;
   logic [fpdt_pkg::CNT_W:0]      total;
   logic [PW-1:0]                 pos;
   logic [WORD_BITS-1:0]          mag_w;
   logic [fpdt_pkg::RAW_W-1:0]    mag;
   logic [fpdt_pkg::WHOLE_W-1:0]  frac;
   logic [fpdt_pkg::RAW_W-1:0]    whole_c;
   logic [fpdt_pkg::RAW_W-1:0]    int_mask;
   fpdt_pkg::round_ctl_type       rctl;
   logic [fpdt_pkg::THOU_W-1:0]   rnd_thou;
   logic                          rnd_carry;

   assign csr_ready = 1'b1;

   always_comb begin
      int_bits_in  = int_bits_ff;
      frac_bits_in = frac_bits_ff;
      mode_in      = mode_ff;
      if (csr_valid) begin
         case (csr_index)
            fpdt_pkg::CSR_INT_BITS: begin
               int_bits_in = csr_wdata[fpdt_pkg::CNT_W-1:0];
            end
            fpdt_pkg::CSR_FRAC_BITS: begin
               frac_bits_in = csr_wdata[fpdt_pkg::CNT_W-1:0];
            end
            fpdt_pkg::CSR_ROUND_MODE: begin
               mode_in = fpdt_pkg::round_mode_type'(csr_wdata[1:0]);
            end
            default: begin
               int_bits_in = int_bits_ff;
            end
         endcase
      end
   end

   // stage advance with bubble collapse
   assign s3_adv    = !out_valid_ff || rsp_ready;
   assign s2_adv    = !s2_valid_ff || s3_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign req_ready = s1_adv;

   always_comb begin
      s1_valid_in = s1_adv ? req_valid : s1_valid_ff;
      raw_in      = (s1_adv && req_valid) ? req_raw_value[WORD_BITS-1:0] : raw_ff;
   end

   always_comb begin
      total = {1'b0, int_bits_ff} + {1'b0, frac_bits_ff};
      if (total > (fpdt_pkg::CNT_W+1)'(WORD_BITS)) begin
         pos = PW'(WORD_BITS - 1);
      end else begin
         pos = PW'(total - (fpdt_pkg::CNT_W+1)'(1));
      end
      neg_in  = (total != '0) && raw_ff[pos];
      mag_w   = neg_in ? (~raw_ff + WORD_BITS'(1)) : raw_ff;
      mag     = fpdt_pkg::RAW_W'(mag_w);
      whole_in = mag >> frac_bits_ff;
      frac    = fpdt_pkg::WHOLE_W'(mag & ((fpdt_pkg::RAW_W'(1) << frac_bits_ff)
                                          - fpdt_pkg::RAW_W'(1)));
      scaled_in   = fpdt_pkg::SCALED_W'(frac) * fpdt_pkg::SCALED_W'(fpdt_pkg::SCALE);
      s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
   end

   assign rctl.mode      = mode_ff;
   assign rctl.frac_bits = frac_bits_ff;
   assign rctl.negative  = neg_ff;

   fpdt_round u_round (
      .scaled      (scaled_ff),
      .ctl         (rctl),
      .thousandths (rnd_thou),
      .carry       (rnd_carry)
   );

   always_comb begin
      int_mask     = (fpdt_pkg::RAW_W'(1) << int_bits_ff) - fpdt_pkg::RAW_W'(1);
      whole_c      = (whole_ff + fpdt_pkg::RAW_W'(rnd_carry)) & int_mask;
      out_valid_in = s3_adv ? s2_valid_ff : out_valid_ff;
      out_neg_in   = neg_ff;
      out_whole_in = whole_c[fpdt_pkg::WHOLE_W-1:0];
      out_thou_in  = rnd_thou;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_bits_ff  <= fpdt_pkg::INT_BITS_RST;
         frac_bits_ff <= fpdt_pkg::FRAC_BITS_RST;
         mode_ff      <= fpdt_pkg::RND_TRUNC;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         int_bits_ff  <= int_bits_in;
         frac_bits_ff <= frac_bits_in;
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;
      if (s2_adv) begin
         neg_ff    <= neg_in;
         whole_ff  <= whole_in;
         scaled_ff <= scaled_in;
      end
      if (s3_adv) begin
         out_neg_ff   <= out_neg_in;
         out_whole_ff <= out_whole_in;
         out_thou_ff  <= out_thou_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_negative    = out_neg_ff;
   assign rsp_whole_part  = out_whole_ff;
   assign rsp_thousandths = out_thou_ff;

endmodule

### rtl/fpdt_checker.sv
// ----------------------------------------------------------------------------
// fpdt_checker
// Port-level checks for the fixed-point to decimal thousandths converter.
// ----------------------------------------------------------------------------
module fpdt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_negative,
   input logic [fpdt_pkg::WHOLE_W-1:0]    rsp_whole_part,
   input logic [fpdt_pkg::THOU_W-1:0]     rsp_thousandths
);

   a_thou_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_thousandths < fpdt_pkg::SCALE))
      else $error("thousandths out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("input not ready after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_negative)
         && $stable(rsp_whole_part) && $stable(rsp_thousandths)))
      else $error("stalled result changed");

endmodule

bind fixed_point_to_decimal_thousandths fpdt_checker u_fpdt_checker (.*);
